// File: sv/tsd_pkg.sv
`timescale 1ns / 1ps

package tsd_pkg;

    // Storage geometry
    localparam int SIDE_DEPTH = 256;
    localparam int DATA_WIDTH = 32;
    localparam int ADDR_W     = $clog2(SIDE_DEPTH);
    localparam int CNT_W      = $clog2(SIDE_DEPTH + 1);
    localparam int TOTAL_W    = CNT_W + 1;
    localparam int POS_W      = 9;

    // Operation codes
    typedef enum logic [1:0] {
        OP_FRONT_PUSH = 2'd0,
        OP_BACK_PUSH  = 2'd1,
        OP_READ       = 2'd2,
        OP_WRITE      = 2'd3
    } tsd_op_t;

    // Status codes
    typedef enum logic [1:0] {
        STAT_OK    = 2'd0,
        STAT_RANGE = 2'd1,
        STAT_FULL  = 2'd2
    } tsd_status_t;

    // Controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_READ
    } tsd_state_t;

    // Controller to datapath commands
    typedef struct packed {
        logic load;    // capture the command fields
        logic exec;    // update stacks and counters, launch a memory read
        logic finish;  // return the memory read data
    } tsd_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic need_read;
    } tsd_stat_t;

endpackage

// File: sv/two_stack_deque.sv
`timescale 1ns / 1ps

// Double-ended store built from a front stack and a back stack.
// Command channel: raise start with operation, position and value; the
// command transfers at the rising edge where start is high and busy is low.
// Operations: push at front, push at back, read at a logical index, write
// at a logical index. Index 0 is the front end.
// Result channel: done is high for exactly one cycle; read_data and status
// transfer in that cycle. count, is_empty, first_value and last_value show
// the state after the latest command and stay valid until the next one.
// Result path: for a push, a write or a rejected command the result registers
// load straight from the command registers; an in-range read first passes
// through the registered read port of the stack memory.
// A new command is taken only after the result of the last one is loaded; busy
// is high from the transfer edge until the result is loaded.
// The receiver cannot hold results off; done is never stretched.
// Reset clears both counters: the store comes up empty with no results
// pending. Stack memory contents are not cleared and need no sweep.
module two_stack_deque
    import tsd_pkg::*;
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [1:0]                   operation,
    input  logic [POS_W-1:0]             position,
    input  logic signed [DATA_WIDTH-1:0] value,
    output logic                         done,
    output logic signed [DATA_WIDTH-1:0] read_data,
    output logic [1:0]                   status,
    output logic [TOTAL_W-1:0]           count,
    output logic                         is_empty,
    output logic signed [DATA_WIDTH-1:0] first_value,
    output logic signed [DATA_WIDTH-1:0] last_value
);

    tsd_cmd_t  cmd;
    tsd_stat_t stat;

    tsd_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy)
    );

    tsd_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .stat        (stat),
        .operation   (operation),
        .position    (position),
        .value       (value),
        .done        (done),
        .read_data   (read_data),
        .status      (status),
        .count       (count),
        .is_empty    (is_empty),
        .first_value (first_value),
        .last_value  (last_value)
    );

endmodule

// File: sv/tsd_ctrl.sv
`timescale 1ns / 1ps

module tsd_ctrl
    import tsd_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    input  tsd_stat_t stat,
    output tsd_cmd_t  cmd,
    output logic      busy
);

    tsd_state_t state_reg;
    tsd_state_t state_next;

    // Hold the state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Sequence one command: capture, execute, optional memory read
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        busy       = 1'b1;
        case (state_reg)
            ST_IDLE:
            begin
                busy = 1'b0;
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                cmd.exec = 1'b1;
                if (stat.need_read)
                begin
                    state_next = ST_READ;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_READ:
            begin
                cmd.finish = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// File: sv/tsd_datapath.sv
`timescale 1ns / 1ps

module tsd_datapath
    import tsd_pkg::*;
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  tsd_cmd_t                     cmd,
    output tsd_stat_t                    stat,
    input  logic [1:0]                   operation,
    input  logic [POS_W-1:0]             position,
    input  logic signed [DATA_WIDTH-1:0] value,
    output logic                         done,
    output logic signed [DATA_WIDTH-1:0] read_data,
    output logic [1:0]                   status,
    output logic [TOTAL_W-1:0]           count,
    output logic                         is_empty,
    output logic signed [DATA_WIDTH-1:0] first_value,
    output logic signed [DATA_WIDTH-1:0] last_value
);

    // Command registers
    tsd_op_t               op_reg;
    logic [POS_W-1:0]      pos_reg;
    logic [DATA_WIDTH-1:0] val_reg;

    // Stack state
    logic [DATA_WIDTH-1:0] front_mem [SIDE_DEPTH];
    logic [DATA_WIDTH-1:0] back_mem  [SIDE_DEPTH];
    logic [CNT_W-1:0]      fc_reg, fc_next;
    logic [CNT_W-1:0]      bc_reg, bc_next;

    // Copies of the stack ends: tops and bottoms
    logic [DATA_WIDTH-1:0] front_top_reg, front_bot_reg;
    logic [DATA_WIDTH-1:0] back_top_reg, back_bot_reg;

    // Read path and result registers
    logic [DATA_WIDTH-1:0] front_rdata_reg, back_rdata_reg;
    logic                  rd_front_reg;
    logic [DATA_WIDTH-1:0] read_data_reg;
    tsd_status_t           status_reg;
    logic                  done_reg;

    // Execute-stage decode
    logic [TOTAL_W-1:0]    total;
    logic [TOTAL_W-1:0]    pos_ext;
    logic                  in_range;
    logic                  is_front;
    logic [ADDR_W-1:0]     front_addr, back_addr;
    logic [ADDR_W-1:0]     front_waddr, back_waddr;
    logic                  front_we, back_we, front_re, back_re;
    logic [DATA_WIDTH-1:0] exec_rdata;
    tsd_status_t           exec_status;
    logic                  out_load;

    assign total   = TOTAL_W'(fc_reg) + TOTAL_W'(bc_reg);
    assign pos_ext = TOTAL_W'(pos_reg);
    assign in_range = pos_ext < total;
    assign is_front = pos_ext < TOTAL_W'(fc_reg);
    assign front_addr = ADDR_W'(TOTAL_W'(fc_reg) - TOTAL_W'(1) - pos_ext);
    assign back_addr  = ADDR_W'(pos_ext - TOTAL_W'(fc_reg));

    // Decode the held command into stack updates
    always_comb
    begin
        fc_next        = fc_reg;
        bc_next        = bc_reg;
        front_we       = 1'b0;
        back_we        = 1'b0;
        front_re       = 1'b0;
        back_re        = 1'b0;
        front_waddr    = front_addr;
        back_waddr     = back_addr;
        exec_rdata     = '0;
        exec_status    = STAT_OK;
        stat.need_read = 1'b0;
        case (op_reg)
            OP_FRONT_PUSH:
            begin
                if (fc_reg == CNT_W'(SIDE_DEPTH))
                begin
                    exec_status = STAT_FULL;
                end
                else
                begin
                    front_we    = cmd.exec;
                    front_waddr = ADDR_W'(fc_reg);
                    fc_next     = fc_reg + CNT_W'(1);
                end
            end
            OP_BACK_PUSH:
            begin
                if (bc_reg == CNT_W'(SIDE_DEPTH))
                begin
                    exec_status = STAT_FULL;
                end
                else
                begin
                    back_we    = cmd.exec;
                    back_waddr = ADDR_W'(bc_reg);
                    bc_next    = bc_reg + CNT_W'(1);
                end
            end
            OP_READ:
            begin
                if (!in_range)
                begin
                    exec_status = STAT_RANGE;
                end
                else
                begin
                    stat.need_read = 1'b1;
                    front_re       = cmd.exec & is_front;
                    back_re        = cmd.exec & ~is_front;
                end
            end
            OP_WRITE:
            begin
                if (!in_range)
                begin
                    exec_status = STAT_RANGE;
                end
                else
                begin
                    exec_rdata = val_reg;
                    front_we   = cmd.exec & is_front;
                    back_we    = cmd.exec & ~is_front;
                end
            end
            default:
            begin
                exec_status = STAT_OK;
            end
        endcase
    end

    // Capture the command on transfer
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg  <= tsd_op_t'(operation);
            pos_reg <= position;
            val_reg <= value;
        end
    end

    // Advance the stack counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fc_reg <= '0;
            bc_reg <= '0;
        end
        else if (cmd.exec)
        begin
            fc_reg <= fc_next;
            bc_reg <= bc_next;
        end
    end

    // Front stack memory
    always_ff @(posedge clk)
    begin
        if (front_we)
        begin
            front_mem[front_waddr] <= val_reg;
        end
        if (front_re)
        begin
            front_rdata_reg <= front_mem[front_addr];
        end
    end

    // Back stack memory
    always_ff @(posedge clk)
    begin
        if (back_we)
        begin
            back_mem[back_waddr] <= val_reg;
        end
        if (back_re)
        begin
            back_rdata_reg <= back_mem[back_addr];
        end
    end

    // Track the end entries alongside the memory writes
    always_ff @(posedge clk)
    begin
        if (cmd.exec)
        begin
            rd_front_reg <= is_front;
        end
        if (front_we)
        begin
            if (front_waddr == ADDR_W'(fc_next - CNT_W'(1)))
            begin
                front_top_reg <= val_reg;
            end
            if (front_waddr == '0)
            begin
                front_bot_reg <= val_reg;
            end
        end
        if (back_we)
        begin
            if (back_waddr == ADDR_W'(bc_next - CNT_W'(1)))
            begin
                back_top_reg <= val_reg;
            end
            if (back_waddr == '0)
            begin
                back_bot_reg <= val_reg;
            end
        end
    end

    // Load the result once per command
    assign out_load = (cmd.exec & ~stat.need_read) | cmd.finish;

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            if (cmd.finish)
            begin
                read_data_reg <= rd_front_reg ? front_rdata_reg : back_rdata_reg;
                status_reg    <= STAT_OK;
            end
            else
            begin
                read_data_reg <= exec_rdata;
                status_reg    <= exec_status;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= out_load;
        end
    end

    // Drive the result ports
    assign done      = done_reg;
    assign read_data = read_data_reg;
    assign status    = status_reg;
    assign count     = total;
    assign is_empty  = (total == '0);

    always_comb
    begin
        if (fc_reg != '0)
        begin
            first_value = front_top_reg;
        end
        else if (bc_reg != '0)
        begin
            first_value = back_bot_reg;
        end
        else
        begin
            first_value = '0;
        end
        if (bc_reg != '0)
        begin
            last_value = back_top_reg;
        end
        else if (fc_reg != '0)
        begin
            last_value = front_bot_reg;
        end
        else
        begin
            last_value = '0;
        end
    end

endmodule

// File: sv/tsd_checker.sv
`timescale 1ns / 1ps

module tsd_checker
    import tsd_pkg::*;
(
    input logic                         clk,
    input logic                         rst_n,
    input logic                         start,
    input logic                         busy,
    input logic                         done,
    input logic signed [DATA_WIDTH-1:0] read_data,
    input logic [1:0]                   status,
    input logic [TOTAL_W-1:0]           count,
    input logic                         is_empty
);

    // A transfer makes the block busy on the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("busy not raised after a command transfer");

    // No result without a command in flight
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
        else $error("result strobe without a pending command");

    // Results are single-cycle strobes
    assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe held longer than one cycle");

    // Failed commands return no data
    assert property (@(posedge clk) disable iff (!rst_n)
        (done && (status == STAT_RANGE || status == STAT_FULL)) |-> (read_data == '0))
        else $error("error status with nonzero read data");

    // Empty flag tracks the element count
    assert property (@(posedge clk) disable iff (!rst_n)
        is_empty == (count == '0))
        else $error("empty flag disagrees with count");

endmodule

bind two_stack_deque tsd_checker u_tsd_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .done      (done),
    .read_data (read_data),
    .status    (status),
    .count     (count),
    .is_empty  (is_empty)
);
